[sv/olid_pkg.sv]
package olid_pkg;

    // Field widths fixed by the interface.
    localparam int ACTION_W = 2;
    localparam int POS_W    = 7;
    localparam int LEN_W    = 7;

    // Action codes carried on the action port.
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DUMP
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } dp_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        dp_op_t op;
        logic   dump_start;
        logic   load_out;
        logic   status_bit;
        logic   last_bit;
    } olid_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ins_ok;
        logic del_ok;
        logic empty;
        logic dump_last;
    } olid_stat_t;

endpackage

[sv/olid_dpath.sv]
module olid_dpath
    import olid_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int ENTRY_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [POS_W-1:0]       position,
    input  logic [ENTRY_WIDTH-1:0] entry_in,
    input  olid_cmd_t              cmd,
    output olid_stat_t             stat,
    output logic                   status,
    output logic [LEN_W-1:0]       list_length,
    output logic                   has_entry,
    output logic [ENTRY_WIDTH-1:0] entry_out,
    output logic                   last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = 8;

    logic [ENTRY_WIDTH-1:0] cell_reg  [CAPACITY];
    logic [ENTRY_WIDTH-1:0] cell_next [CAPACITY];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;

    logic                   status_reg;
    logic [LEN_W-1:0]       len_reg;
    logic                   has_reg;
    logic [ENTRY_WIDTH-1:0] entry_out_reg;
    logic                   last_reg;

    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] cnt_w;
    logic [CMP_W-1:0] pidx_w;

    assign pos_w  = CMP_W'(position);
    assign cnt_w  = CMP_W'(count_reg);
    assign pidx_w = pos_w - CMP_W'(1);

    assign stat.ins_ok    = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1))
                            && (cnt_w < CMP_W'(CAPACITY));
    assign stat.del_ok    = (pos_w != '0) && (pos_w <= cnt_w);
    assign stat.empty     = (count_reg == '0);
    assign stat.dump_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Per-cell next value: every cell moves in parallel.
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        always_comb
        begin
            cell_next[j] = cell_reg[j];
            case (cmd.op)
                OP_INSERT:
                begin
                    if (CMP_W'(j) == pidx_w) begin
                        cell_next[j] = entry_in;
                    end else if (CMP_W'(j) > pidx_w) begin
                        if (j > 0) begin
                            cell_next[j] = cell_reg[(j > 0) ? j - 1 : 0];
                        end
                    end
                end
                OP_DELETE:
                begin
                    if ((CMP_W'(j) >= pidx_w) && (j < CAPACITY - 1)) begin
                        cell_next[j] = cell_reg[(j < CAPACITY - 1) ? j + 1 : j];
                    end
                end
                OP_ROTATE:
                begin
                    if (CMP_W'(j) + CMP_W'(1) == cnt_w) begin
                        cell_next[j] = cell_reg[0];
                    end else if ((CMP_W'(j) + CMP_W'(1) < cnt_w) && (j < CAPACITY - 1)) begin
                        cell_next[j] = cell_reg[(j < CAPACITY - 1) ? j + 1 : j];
                    end
                end
                default:
                begin
                    cell_next[j] = cell_reg[j];
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            cell_reg[j] <= cell_next[j];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        case (cmd.op)
            OP_INSERT: count_next = count_reg + CNT_W'(1);
            OP_DELETE: count_next = count_reg - CNT_W'(1);
            default:   count_next = count_reg;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.dump_start) begin
            idx_next = '0;
        end else if (cmd.op == OP_ROTATE) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out) begin
            status_reg    <= cmd.status_bit;
            len_reg       <= LEN_W'(count_next);
            has_reg       <= (cmd.op == OP_ROTATE);
            entry_out_reg <= (cmd.op == OP_ROTATE) ? cell_reg[0] : '0;
            last_reg      <= cmd.last_bit;
        end
    end

    assign status      = status_reg;
    assign list_length = len_reg;
    assign has_entry   = has_reg;
    assign entry_out   = entry_out_reg;
    assign last        = last_reg;

endmodule

[sv/olid_ctrl.sv]
module olid_ctrl
    import olid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic [ACTION_W-1:0] action,
    input  olid_stat_t          stat,
    output olid_cmd_t           cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.op         = OP_HOLD;
        cmd.dump_start = 1'b0;
        cmd.load_out   = 1'b0;
        cmd.status_bit = 1'b0;
        cmd.last_bit   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = slot_free;
                if (in_valid && slot_free) begin
                    case (action)
                        ACT_INSERT:
                        begin
                            cmd.op         = stat.ins_ok ? OP_INSERT : OP_HOLD;
                            cmd.load_out   = 1'b1;
                            cmd.status_bit = !stat.ins_ok;
                        end
                        ACT_DELETE:
                        begin
                            cmd.op         = stat.del_ok ? OP_DELETE : OP_HOLD;
                            cmd.load_out   = 1'b1;
                            cmd.status_bit = !stat.del_ok;
                        end
                        ACT_DUMP:
                        begin
                            if (stat.empty) begin
                                cmd.load_out = 1'b1;
                            end else begin
                                cmd.dump_start = 1'b1;
                                state_next     = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            cmd.load_out   = 1'b1;
                            cmd.status_bit = 1'b1;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (slot_free) begin
                    cmd.op       = OP_ROTATE;
                    cmd.load_out = 1'b1;
                    cmd.last_bit = stat.dump_last;
                    if (stat.dump_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/ordered_list_insert_delete_core.sv]
// Ordered list of up to CAPACITY entries held in a row of register cells. An insert or
// delete is applied as the request is taken: the cells from the position onward shift
// in parallel, and a single result transfer follows from the output register. A dump
// takes the request, then for each entry, as the output register has room, rotates the
// cell ring by one and copies cell zero into it; the list is back in its original order
// when the last entry leaves. A dump of an empty list, an error and an unknown action
// each give one result. A new request is taken only when the block is not dumping and
// the output register is empty or being drained in the same cycle.
module ordered_list_insert_delete_core
    import olid_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int ENTRY_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ACTION_W-1:0]    action,
    input  logic [POS_W-1:0]       position,
    input  logic [ENTRY_WIDTH-1:0] entry_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   status,
    output logic [LEN_W-1:0]       list_length,
    output logic                   has_entry,
    output logic [ENTRY_WIDTH-1:0] entry_out,
    output logic                   last
);

    olid_cmd_t  cmd;
    olid_stat_t stat;

    // The controller sequences transfers and dump steps.
    olid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .action    (action),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the cells, the length count and the output register.
    olid_dpath #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .position    (position),
        .entry_in    (entry_in),
        .cmd         (cmd),
        .stat        (stat),
        .status      (status),
        .list_length (list_length),
        .has_entry   (has_entry),
        .entry_out   (entry_out),
        .last        (last)
    );

endmodule
